### hdl/tds_pkg.sv
// Package for the tangent direction suppression core.
// Holds sizes, register indexes and the sequencer state type; no dependencies.
package tds_pkg;
	localparam int MAX_ITEMS    = 64;
	localparam int IDX_W        = $clog2(MAX_ITEMS);
	localparam int CNT_W        = IDX_W + 1;
	localparam int RESULT_LIMIT = 64;
	localparam int KL_W         = $clog2(RESULT_LIMIT);
	localparam int KCNT_W       = KL_W + 1;
	localparam int PADDR_W      = 4;

	localparam logic [1:0] REG_SCORE_RATIO = 2'd0;
	localparam logic [1:0] REG_MIN_KEPT    = 2'd1;
	localparam logic [1:0] REG_COS_SQ      = 2'd2;

	localparam logic [3:0] RATIO_RESET = 4'd4;
	localparam logic [5:0] MINK_RESET  = 6'd5;
	localparam logic [15:0] COS_RESET  = 16'd32768;

	// multiplier step codes
	localparam logic [3:0] STEP_DOT_X = 4'd0;
	localparam logic [3:0] STEP_DOT_Y = 4'd1;
	localparam logic [3:0] STEP_DOT_Z = 4'd2;
	localparam logic [3:0] STEP_NA_X  = 4'd3;
	localparam logic [3:0] STEP_NA_Y  = 4'd4;
	localparam logic [3:0] STEP_NA_Z  = 4'd5;
	localparam logic [3:0] STEP_NB_X  = 4'd6;
	localparam logic [3:0] STEP_NB_Y  = 4'd7;
	localparam logic [3:0] STEP_NB_Z  = 4'd8;
	localparam logic [3:0] STEP_DD    = 4'd9;
	localparam logic [3:0] STEP_NN    = 4'd10;
	localparam logic [3:0] STEP_RLO   = 4'd11;
	localparam logic [3:0] STEP_RHI   = 4'd12;
	localparam logic [3:0] STEP_CMP   = 4'd13;

	typedef enum logic [3:0] {
		ST_IDLE, ST_INS_RD, ST_INS_CMP, ST_INS_WR, ST_SCAN_INIT, ST_SCAN_BEST,
		ST_SCAN_ITEM, ST_SCAN_CHK, ST_KEPT_NEXT, ST_KEPT_RD, ST_VEC_RD, ST_MUL,
		ST_OUT_RD, ST_OUT_RD2, ST_OUT_LOAD, ST_OUT_WAIT
	} state_t;
endpackage

### hdl/tds_if.sv
// Valid/ready channel interfaces for input items and kept results.
// Depends on nothing.
interface tds_in_if;
	logic valid;
	logic ready;
	logic signed [15:0] comp_x;
	logic signed [15:0] comp_y;
	logic signed [15:0] comp_z;
	logic [31:0] score;
	logic last;
	modport source (output valid, comp_x, comp_y, comp_z, score, last, input ready);
	modport sink (input valid, comp_x, comp_y, comp_z, score, last, output ready);
endinterface

interface tds_out_if;
	logic valid;
	logic ready;
	logic [5:0] sorted_position;
	logic [5:0] arrival_index;
	logic signed [15:0] out_x;
	logic signed [15:0] out_y;
	logic signed [15:0] out_z;
	logic [31:0] out_score;
	logic out_last;
	modport source (output valid, sorted_position, arrival_index, out_x, out_y, out_z,
		out_score, out_last, input ready);
	modport sink (input valid, sorted_position, arrival_index, out_x, out_y, out_z,
		out_score, out_last, output ready);
endinterface

### hdl/tangent_direction_suppression_core.sv
// A load does a sorted insert: each stored entry with a higher score is shifted up one place
// before the new item is written (one write port for the store).
// A last item then scans the store in score order and checks each item against each kept item
// (one shared 33x33 multiplier), cutting a check short when the dot product is not positive;
// each result then waits for the output handshake. One transaction at a time: in.ready only in idle.
// Reset (arst_n low, async): counts cleared, registers to 4 / 5 / 32768; stores stay undefined.
module tangent_direction_suppression_core (
	input  logic clk,
	input  logic arst_n,
	tds_in_if.sink    in_ch,
	tds_out_if.source out_ch,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [tds_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import tds_pkg::*;

	// configuration registers
	logic [3:0]  ratio_q;
	logic [5:0]  mink_q;
	logic [15:0] cos_q;

	state_t state_q, state_d;

	// sorted item store: vector, score, arrival; two registered read ports
	logic [47:0]      vec_mem [MAX_ITEMS];
	logic [31:0]      score_mem [MAX_ITEMS];
	logic [IDX_W-1:0] arr_mem [MAX_ITEMS];
	logic [KL_W-1:0]  kl_mem [RESULT_LIMIT];

	logic [47:0] rd_vec_a_q, rd_vec_b_q;
	logic [31:0] rd_score_a_q;
	logic [IDX_W-1:0] rd_arr_a_q;
	logic [KL_W-1:0] kl_rd_q;

	logic we;
	logic [IDX_W-1:0] waddr, raddr_a, raddr_b;
	logic [47:0] wvec;
	logic [31:0] wscore;
	logic [IDX_W-1:0] warr;
	logic kl_we;
	logic [KL_W-1:0] kl_raddr;

	// counters and item registers
	logic [CNT_W-1:0] item_count_q, i_q;
	logic [KCNT_W-1:0] kept_q, k_q;
	logic [IDX_W-1:0] pos_q;
	logic [47:0] new_vec_q;
	logic [31:0] new_score_q;
	logic new_last_q;
	logic [35:0] bound_q;

	// check datapath
	logic [47:0] a_vec_q, b_vec_q;
	logic [3:0] step_q;
	logic signed [33:0] dot_q;
	logic [33:0] na_q, nb_q;
	logic [63:0] dd_q, nn_q;
	logic [47:0] rlo_q, rhi_q;
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod;
	logic [79:0] lhs, rhs;
	logic close;

	logic in_acc, out_acc, full, scan_done, stop_hit, ins_shift, last_out;

	assign in_acc  = in_ch.valid && in_ch.ready;
	assign out_acc = out_ch.valid && out_ch.ready;
	assign full    = (item_count_q == CNT_W'(MAX_ITEMS));
	assign scan_done = (i_q == item_count_q) || (kept_q == KCNT_W'(RESULT_LIMIT));
	assign stop_hit  = (kept_q > KCNT_W'(mink_q)) && ({4'b0, rd_score_a_q} > bound_q);
	assign ins_shift = (rd_score_a_q > new_score_q);
	assign last_out  = (k_q + KCNT_W'(1) == kept_q);

	// APB
	assign pready = 1'b1;
	always_comb begin
		case (paddr[3:2])
			REG_SCORE_RATIO: prdata = {28'b0, ratio_q};
			REG_MIN_KEPT:    prdata = {26'b0, mink_q};
			REG_COS_SQ:      prdata = {16'b0, cos_q};
			default:         prdata = 32'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q <= RATIO_RESET;
			mink_q  <= MINK_RESET;
			cos_q   <= COS_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_SCORE_RATIO: ratio_q <= pwdata[3:0];
				REG_MIN_KEPT:    mink_q  <= pwdata[5:0];
				REG_COS_SQ:      cos_q   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (step_q)
			STEP_DOT_X: begin mul_a = 33'(signed'(a_vec_q[15:0]));  mul_b = 33'(signed'(b_vec_q[15:0])); end
			STEP_DOT_Y: begin mul_a = 33'(signed'(a_vec_q[31:16])); mul_b = 33'(signed'(b_vec_q[31:16])); end
			STEP_DOT_Z: begin mul_a = 33'(signed'(a_vec_q[47:32])); mul_b = 33'(signed'(b_vec_q[47:32])); end
			STEP_NA_X:  begin mul_a = 33'(signed'(a_vec_q[15:0]));  mul_b = 33'(signed'(a_vec_q[15:0])); end
			STEP_NA_Y:  begin mul_a = 33'(signed'(a_vec_q[31:16])); mul_b = 33'(signed'(a_vec_q[31:16])); end
			STEP_NA_Z:  begin mul_a = 33'(signed'(a_vec_q[47:32])); mul_b = 33'(signed'(a_vec_q[47:32])); end
			STEP_NB_X:  begin mul_a = 33'(signed'(b_vec_q[15:0]));  mul_b = 33'(signed'(b_vec_q[15:0])); end
			STEP_NB_Y:  begin mul_a = 33'(signed'(b_vec_q[31:16])); mul_b = 33'(signed'(b_vec_q[31:16])); end
			STEP_NB_Z:  begin mul_a = 33'(signed'(b_vec_q[47:32])); mul_b = 33'(signed'(b_vec_q[47:32])); end
			STEP_DD:    begin mul_a = dot_q[32:0]; mul_b = dot_q[32:0]; end
			STEP_NN:    begin mul_a = {1'b0, na_q[31:0]}; mul_b = {1'b0, nb_q[31:0]}; end
			STEP_RLO:   begin mul_a = {1'b0, nn_q[31:0]}; mul_b = {17'b0, cos_q}; end
			STEP_RHI:   begin mul_a = {1'b0, nn_q[63:32]}; mul_b = {17'b0, cos_q}; end
			default: ;
		endcase
	end
	assign prod = mul_a * mul_b;
	// dot^2 * 2^16 against |a|^2 |b|^2 cos^2, exact at 80 bits
	assign lhs = {dd_q, 16'b0};
	assign rhs = {rhi_q, 32'b0} + {32'b0, rlo_q};
	assign close = lhs > rhs;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_acc) begin
				if (full) state_d = in_ch.last ? ST_SCAN_INIT : ST_IDLE;
				else if (item_count_q == '0) state_d = ST_INS_WR;
				else state_d = ST_INS_RD;
			end
			ST_INS_RD:  state_d = ST_INS_CMP;
			ST_INS_CMP: state_d = (ins_shift && pos_q != IDX_W'(1)) ? ST_INS_RD : ST_INS_WR;
			ST_INS_WR:  state_d = new_last_q ? ST_SCAN_INIT : ST_IDLE;
			ST_SCAN_INIT: state_d = ST_SCAN_BEST;
			ST_SCAN_BEST: state_d = ST_SCAN_ITEM;
			ST_SCAN_ITEM: begin
				if (scan_done) state_d = (kept_q == '0) ? ST_IDLE : ST_OUT_RD;
				else state_d = ST_SCAN_CHK;
			end
			ST_SCAN_CHK: state_d = stop_hit ? ((kept_q == '0) ? ST_IDLE : ST_OUT_RD)
				: ST_KEPT_NEXT;
			ST_KEPT_NEXT: state_d = (k_q == kept_q) ? ST_SCAN_ITEM : ST_KEPT_RD;
			ST_KEPT_RD:   state_d = ST_VEC_RD;
			ST_VEC_RD:    state_d = ST_MUL;
			ST_MUL: begin
				if (step_q == STEP_DD && dot_q <= 0) state_d = ST_KEPT_NEXT;
				else if (step_q == STEP_CMP) state_d = close ? ST_SCAN_ITEM : ST_KEPT_NEXT;
			end
			ST_OUT_RD:   state_d = ST_OUT_RD2;
			ST_OUT_RD2:  state_d = ST_OUT_LOAD;
			ST_OUT_LOAD: state_d = ST_OUT_WAIT;
			ST_OUT_WAIT: if (out_acc) state_d = last_out ? ST_IDLE : ST_OUT_RD;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs: handshake and memory controls
	always_comb begin
		in_ch.ready  = (state_q == ST_IDLE);
		out_ch.valid = (state_q == ST_OUT_WAIT);
		we = 1'b0;
		waddr = pos_q;
		wvec = new_vec_q;
		wscore = new_score_q;
		warr = item_count_q[IDX_W-1:0];
		raddr_a = '0;
		raddr_b = '0;
		kl_we = 1'b0;
		kl_raddr = k_q[KL_W-1:0];
		case (state_q)
			ST_INS_RD: raddr_a = pos_q - IDX_W'(1);
			ST_INS_CMP: if (ins_shift) begin
				we = 1'b1;
				wvec = rd_vec_a_q;
				wscore = rd_score_a_q;
				warr = rd_arr_a_q;
			end
			ST_INS_WR: we = 1'b1;
			ST_SCAN_ITEM: raddr_a = i_q[IDX_W-1:0];
			ST_KEPT_NEXT: kl_we = (k_q == kept_q);
			ST_KEPT_RD: raddr_b = IDX_W'(kl_rd_q);
			ST_OUT_RD2: raddr_a = IDX_W'(kl_rd_q);
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			vec_mem[waddr] <= wvec;
			score_mem[waddr] <= wscore;
			arr_mem[waddr] <= warr;
		end
		rd_vec_a_q <= vec_mem[raddr_a];
		rd_score_a_q <= score_mem[raddr_a];
		rd_arr_a_q <= arr_mem[raddr_a];
		rd_vec_b_q <= vec_mem[raddr_b];
		if (kl_we) kl_mem[kept_q[KL_W-1:0]] <= i_q[KL_W-1:0];
		kl_rd_q <= kl_mem[kl_raddr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			item_count_q <= '0;
			kept_q <= '0;
			i_q <= '0;
			k_q <= '0;
			pos_q <= '0;
			step_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: if (in_acc) pos_q <= item_count_q[IDX_W-1:0];
				ST_INS_CMP: if (ins_shift) pos_q <= pos_q - IDX_W'(1);
				ST_INS_WR: item_count_q <= item_count_q + CNT_W'(1);
				ST_SCAN_BEST: begin
					i_q <= '0;
					kept_q <= '0;
				end
				ST_SCAN_ITEM: begin
					k_q <= '0;
					if (scan_done && kept_q == '0) item_count_q <= '0;
				end
				ST_SCAN_CHK: begin
					k_q <= '0;
					if (stop_hit && kept_q == '0) item_count_q <= '0;
				end
				ST_KEPT_NEXT: if (k_q == kept_q) begin
					kept_q <= kept_q + KCNT_W'(1);
					i_q <= i_q + CNT_W'(1);
				end
				ST_VEC_RD: step_q <= STEP_DOT_X;
				ST_MUL: begin
					step_q <= step_q + 4'd1;
					if (step_q == STEP_DD && dot_q <= 0) k_q <= k_q + KCNT_W'(1);
					else if (step_q == STEP_CMP) begin
						if (close) i_q <= i_q + CNT_W'(1);
						else k_q <= k_q + KCNT_W'(1);
					end
				end
				ST_OUT_WAIT: if (out_acc) begin
					if (last_out) item_count_q <= '0;
					else k_q <= k_q + KCNT_W'(1);
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			new_vec_q <= {in_ch.comp_z, in_ch.comp_y, in_ch.comp_x};
			new_score_q <= in_ch.score;
			new_last_q <= in_ch.last;
		end
		if (state_q == ST_SCAN_BEST) bound_q <= 36'(ratio_q) * 36'(rd_score_a_q);
		if (state_q == ST_SCAN_CHK) a_vec_q <= rd_vec_a_q;
		if (state_q == ST_VEC_RD) b_vec_q <= rd_vec_b_q;
		if (state_q == ST_MUL) begin
			case (step_q)
				STEP_DOT_X: dot_q <= prod[33:0];
				STEP_DOT_Y, STEP_DOT_Z: dot_q <= dot_q + prod[33:0];
				STEP_NA_X: na_q <= prod[33:0];
				STEP_NA_Y, STEP_NA_Z: na_q <= na_q + prod[33:0];
				STEP_NB_X: nb_q <= prod[33:0];
				STEP_NB_Y, STEP_NB_Z: nb_q <= nb_q + prod[33:0];
				STEP_DD: dd_q <= prod[63:0];
				STEP_NN: nn_q <= prod[63:0];
				STEP_RLO: rlo_q <= prod[47:0];
				STEP_RHI: rhi_q <= prod[47:0];
				default: ;
			endcase
		end
		if (state_q == ST_OUT_LOAD) begin
			out_ch.sorted_position <= 6'(kl_rd_q);
			out_ch.arrival_index <= 6'(rd_arr_a_q);
			out_ch.out_x <= rd_vec_a_q[15:0];
			out_ch.out_y <= rd_vec_a_q[31:16];
			out_ch.out_z <= rd_vec_a_q[47:32];
			out_ch.out_score <= rd_score_a_q;
			out_ch.out_last <= last_out;
		end
	end
endmodule

### hdl/tds_checker.sv
// Port-level checks for the tangent direction suppression core, with bind.
// Depends on the core's ports.
module tds_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_last,
	input logic [31:0] out_score
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_score) && $stable(out_last))
		else $error("result dropped or changed while stalled");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input accepted while a result is pending");

	a_more: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=> !in_ready)
		else $error("input accepted before the last result");

	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_last |=> in_ready)
		else $error("block not idle after the last result");
endmodule

bind tangent_direction_suppression_core tds_checker u_tds_checker (
	.clk(clk), .arst_n(arst_n),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_last(out_ch.out_last), .out_score(out_ch.out_score)
);
